@@ design/slm3_pkg.sv @@
// Package for the step-limited 3-D move pipeline.
// Holds widths, stage counts and the payload/pipeline structs; no dependencies.
package slm3_pkg;

  localparam int CoordW   = 16;
  localparam int FracBits = 24;
  localparam int DiffW    = CoordW + 1;
  localparam int SqW      = 2 * DiffW;
  localparam int Dist2W   = SqW + 2;
  localparam int Lim2W    = 2 * CoordW;
  localparam int QW       = 2 * FracBits;
  localparam int RemW     = Dist2W + 1;
  localparam int DivSteps = QW;
  localparam int SqrtSteps = FracBits;
  localparam int SqRemW   = FracBits + 3;
  localparam int MulW     = DiffW + FracBits + 1;
  localparam int AccW     = CoordW + FracBits + 2;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    point_t                  cur;
    point_t                  goal;
    logic [CoordW-1:0]       lim;
  } move_req_t;

  typedef struct packed {
    point_t                  pos;
    logic                    reached;
  } move_rsp_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
  } diff_t;

  // Per-stage side data carried along the divide and root pipelines
  typedef struct packed {
    point_t                  cur;
    point_t                  goal;
    diff_t                   d;
    logic                    reached;
  } side_t;

endpackage

@@ design/slm3_if.sv @@
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on slm3_pkg.
interface slm3_req_if
  import slm3_pkg::*;
  ();
  logic      valid;
  logic      ready;
  move_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slm3_rsp_if
  import slm3_pkg::*;
  ();
  logic      valid;
  logic      ready;
  move_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/slm3_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
// Computes floor(num * 2^QW / den) for num < den. Depends on slm3_pkg.
module slm3_div
  import slm3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RemW-1:0]   num,
  input  logic [Dist2W-1:0] den,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [QW-1:0]     quo,
  output side_t             out_side
);

  logic [RemW-1:0]   rem  [DivSteps+1];
  logic [Dist2W-1:0] dv   [DivSteps+1];
  logic [QW-1:0]     qv   [DivSteps+1];
  side_t             sd   [DivSteps+1];
  logic [DivSteps:0] vld;

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qv[0]  = '0;
  assign sd[0]  = in_side;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [RemW-1:0] sh;
    logic            ge;
    // Shift in a zero, compare and subtract
    assign sh = {rem[i][RemW-2:0], 1'b0};
    assign ge = sh >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? sh - {1'b0, dv[i]} : sh;
        qv[i+1]  <= {qv[i][QW-2:0], ge};
        dv[i+1]  <= dv[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[DivSteps];
  assign quo       = qv[DivSteps];
  assign out_side  = sd[DivSteps];

endmodule

@@ design/slm3_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one result bit per stage.
// floor(sqrt(q)) for a QW-bit q gives a FracBits-bit root. Depends on slm3_pkg.
module slm3_sqrt
  import slm3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QW-1:0]     q,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [FracBits-1:0] root,
  output side_t             out_side
);

  logic [SqRemW-1:0]   rem [SqrtSteps+1];
  logic [FracBits-1:0] rt  [SqrtSteps+1];
  logic [QW-1:0]       src [SqrtSteps+1];
  side_t               sd  [SqrtSteps+1];
  logic [SqrtSteps:0]  vld;

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign src[0] = q;
  assign sd[0]  = in_side;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    logic [SqRemW-1:0] r2;
    logic [SqRemW-1:0] trial;
    logic              ge;
    // Bring down two bits, try (4*root + 1)
    assign r2    = {rem[i][SqRemW-3:0], src[i][QW-1:QW-2]};
    assign trial = {1'b0, rt[i], 2'b01};
    assign ge    = r2 >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? r2 - trial : r2;
        rt[i+1]  <= {rt[i][FracBits-2:0], ge};
        src[i+1] <= {src[i][QW-3:0], 2'b00};
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[SqrtSteps];
  assign root      = rt[SqrtSteps];
  assign out_side  = sd[SqrtSteps];

endmodule

@@ design/step_limited_move_3d.sv @@
// Top level of the step-limited 3-D move: front end, divider, root, scale.
// Depends on slm3_pkg, slm3_if, slm3_div, slm3_sqrt.
//
//   channel   | dir | beat contents
//   ----------+-----+------------------------------------------
//   req       | in  | cur_x/y/z, goal_x/y/z, step_limit
//   rsp       | out | new_x/y/z, reached
//
// One beat enters per cycle while the pipeline is not stalled; the divider
// has 48 one-bit stages and the square root 24.
// Reset (synchronous) clears only the valid bits.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
module step_limited_move_3d
  import slm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  slm3_req_if.sink    req,
  slm3_rsp_if.source  rsp
);

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Stage 1: differences
  logic  s1_v;
  side_t s1_side;
  logic [CoordW-1:0] s1_lim;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= req.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.cur  <= req.data.cur;
      s1_side.goal <= req.data.goal;
      s1_side.d.dx <= DiffW'(req.data.goal.x) - DiffW'(req.data.cur.x);
      s1_side.d.dy <= DiffW'(req.data.goal.y) - DiffW'(req.data.cur.y);
      s1_side.d.dz <= DiffW'(req.data.goal.z) - DiffW'(req.data.cur.z);
      s1_side.reached <= 1'b0;
      s1_lim <= req.data.lim;
    end
  end

  // Stage 2: squares
  logic  s2_v;
  side_t s2_side;
  logic [SqW-1:0]   sqx, sqy, sqz;
  logic [Lim2W-1:0] s2_lim2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqx     <= SqW'(s1_side.d.dx * s1_side.d.dx);
      sqy     <= SqW'(s1_side.d.dy * s1_side.d.dy);
      sqz     <= SqW'(s1_side.d.dz * s1_side.d.dz);
      s2_lim2 <= s1_lim * s1_lim;
      s2_side <= s1_side;
    end
  end

  // Stage 3: distance sum and limit test
  logic  s3_v;
  side_t s3_side;
  logic [Dist2W-1:0] s3_dist2;
  logic [Lim2W-1:0]  s3_lim2;
  logic [Dist2W-1:0] dist2_c;
  assign dist2_c = Dist2W'(sqx) + Dist2W'(sqy) + Dist2W'(sqz);
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_dist2 <= dist2_c;
      s3_lim2  <= s2_lim2;
      s3_side.cur  <= s2_side.cur;
      s3_side.goal <= s2_side.goal;
      s3_side.d    <= s2_side.d;
      s3_side.reached <= Dist2W'(s2_lim2) >= dist2_c;
    end
  end

  // Divide and root; a reached item divides 0 by 1 and is ignored later
  logic              dv_v, sq_v;
  logic [QW-1:0]     quo;
  logic [FracBits-1:0] frac;
  side_t             dv_side, sq_side;
  logic [Dist2W-1:0] den;
  logic [RemW-1:0]   num;
  assign den = s3_side.reached ? Dist2W'(1) : s3_dist2;
  assign num = s3_side.reached ? '0 : RemW'(s3_lim2);

  slm3_div u_div (
    .clk, .rst, .en,
    .in_valid (s3_v), .num (num), .den (den), .in_side (s3_side),
    .out_valid (dv_v), .quo (quo), .out_side (dv_side)
  );

  slm3_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid (dv_v), .q (quo), .in_side (dv_side),
    .out_valid (sq_v), .root (frac), .out_side (sq_side)
  );

  // Scale stage: d * frac products
  logic  sc_v;
  side_t sc_side;
  logic signed [MulW-1:0] px, py, pz;
  logic signed [FracBits:0] frac_s;
  assign frac_s = {1'b0, frac};
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
    end else if (en) begin
      sc_v <= sq_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px      <= MulW'(sq_side.d.dx * frac_s);
      py      <= MulW'(sq_side.d.dy * frac_s);
      pz      <= MulW'(sq_side.d.dz * frac_s);
      sc_side <= sq_side;
    end
  end

  // Final: trunc-toward-zero((cur*2^F + d*frac) / 2^F) on each axis
  function automatic logic [CoordW-1:0] axis_out(logic signed [CoordW-1:0] c,
                                                 logic signed [MulW-1:0] p);
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] adj;
    begin
      acc = (AccW'(c) <<< FracBits) + AccW'(p);
      // bias negative values so the shift truncates toward zero
      adj = acc[AccW-1] ? acc + AccW'((1 << FracBits) - 1) : acc;
      axis_out = adj[FracBits +: CoordW];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= sc_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.data.reached <= sc_side.reached;
      if (sc_side.reached) begin
        rsp.data.pos <= sc_side.goal;
      end else begin
        rsp.data.pos.x <= axis_out(sc_side.cur.x, px);
        rsp.data.pos.y <= axis_out(sc_side.cur.y, py);
        rsp.data.pos.z <= axis_out(sc_side.cur.z, pz);
      end
    end
  end

endmodule

@@ design/slm3_check.sv @@
// Port-level checker for step_limited_move_3d, bound to the top level.
// Depends on slm3_pkg.
module slm3_check
  import slm3_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input move_rsp_t rsp_data
);

  // Input side is ready whenever the output beat is absent or taken
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("req not ready while output free");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled result changed");

  // No result appears right after reset
  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind step_limited_move_3d slm3_check u_slm3_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

@@ bench/step_limited_move_3d_test.sv @@
// Self-checking bench for step_limited_move_3d: directed table, then random beats.
// Depends on slm3_pkg, slm3_if and step_limited_move_3d; predicts each result and compares in order.
module step_limited_move_3d_test;
  import slm3_pkg::*;

  localparam int LatencyCycles = 77;
  localparam int WatchLimit    = 4000;
  localparam int RandomBeats   = 1330;
  localparam int HoldCycles    = 300;

  typedef struct {
    move_req_t req;
    logic      has_rsp;
    move_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slm3_req_if req_ch ();
  slm3_rsp_if rsp_ch ();

  step_limited_move_3d u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  move_rsp_t moves_due[$];
  int        errors = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  logic      hold_rsp = 1'b0;
  int        quiet_cycles = 0;

  // floor(sqrt(v)) by bit-pair search
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Predict the moved point for one request beat
  function automatic move_rsp_t predict_move(move_req_t r);
    move_rsp_t         o;
    logic signed [63:0] c[3];
    logic signed [63:0] d[3];
    logic signed [63:0] acc;
    logic [63:0]       dist2;
    logic [63:0]       lim2;
    logic [127:0]      quot;
    logic [63:0]       frac;
    logic signed [CoordW-1:0] np[3];
    c[0] = r.cur.x;  c[1] = r.cur.y;  c[2] = r.cur.z;
    d[0] = 64'(signed'(r.goal.x)) - c[0];
    d[1] = 64'(signed'(r.goal.y)) - c[1];
    d[2] = 64'(signed'(r.goal.z)) - c[2];
    dist2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    lim2  = 64'(r.lim) * 64'(r.lim);
    if (lim2 >= dist2) begin
      o.pos     = r.goal;
      o.reached = 1'b1;
      return o;
    end
    quot = (128'(lim2) << (2 * FracBits)) / 128'(dist2);
    frac = root_floor(quot[63:0]);
    for (int k = 0; k < 3; k++) begin
      acc = c[k] * (64'sd1 <<< FracBits) + d[k] * signed'(frac);
      // truncate toward zero
      if (acc < 0) acc = -((-acc) >>> FracBits);
      else acc = acc >>> FracBits;
      np[k] = acc[CoordW-1:0];
    end
    o.pos.x   = np[0];
    o.pos.y   = np[1];
    o.pos.z   = np[2];
    o.reached = 1'b0;
    return o;
  endfunction

  function automatic move_req_t mk_req(int cx, int cy, int cz, int gx, int gy, int gz,
                                       int lim);
    move_req_t r;
    r.cur.x  = cx[15:0];  r.cur.y  = cy[15:0];  r.cur.z  = cz[15:0];
    r.goal.x = gx[15:0];  r.goal.y = gy[15:0];  r.goal.z = gz[15:0];
    r.lim    = lim[15:0];
    return r;
  endfunction

  function automatic move_rsp_t mk_rsp(int x, int y, int z, bit hit);
    move_rsp_t o;
    o.pos.x = x[15:0];  o.pos.y = y[15:0];  o.pos.z = z[15:0];
    o.reached = hit;
    return o;
  endfunction

  function automatic move_req_t rand_req();
    move_req_t r;
    int        mode;
    r    = move_req_t'(112'({$urandom, $urandom, $urandom, $urandom}));
    mode = $urandom_range(0, 7);
    // bias toward close targets and limits near the distance
    if (mode < 3) begin
      r.goal.x = r.cur.x + 16'($signed($urandom_range(0, 200)) - 100);
      r.goal.y = r.cur.y + 16'($signed($urandom_range(0, 200)) - 100);
      r.goal.z = r.cur.z + 16'($signed($urandom_range(0, 200)) - 100);
      r.lim    = 16'($urandom_range(0, 180));
    end else if (mode == 3) begin
      r.lim = 16'($urandom_range(0, 15));
    end else if (mode == 4) begin
      r.goal = r.cur;
    end
    return r;
  endfunction

  // Source: push one beat, keep valid high across back-to-back beats
  task automatic send_beat(move_req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    moves_due.push_back(predict_move(r));
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Directed rows: check the predictor against results readable by eye
  task automatic check_directed(dir_row_t row);
    move_rsp_t p;
    p = predict_move(row.req);
    if (row.has_rsp && p != row.rsp) begin
      $display("%0t directed row predictor: expected %h actual %h", $time, row.rsp, p);
      errors++;
    end
  endtask

  // Sink side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Compare each response beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (moves_due.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, rsp_ch.data);
        errors++;
      end else begin
        move_rsp_t e;
        e = moves_due.pop_front();
        if (e.pos.x != rsp_ch.data.pos.x) begin
          $display("%0t new_x: expected %0d actual %0d", $time, e.pos.x, rsp_ch.data.pos.x);
          errors++;
        end
        if (e.pos.y != rsp_ch.data.pos.y) begin
          $display("%0t new_y: expected %0d actual %0d", $time, e.pos.y, rsp_ch.data.pos.y);
          errors++;
        end
        if (e.pos.z != rsp_ch.data.pos.z) begin
          $display("%0t new_z: expected %0d actual %0d", $time, e.pos.z, rsp_ch.data.pos.z);
          errors++;
        end
        if (e.reached != rsp_ch.data.reached) begin
          $display("%0t reached: expected %0b actual %0b", $time, e.reached,
                   rsp_ch.data.reached);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (src_idle_pct == 0 && snk_idle_pct == 0 && !rst);
    hold_rsp <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin
    dir_row_t rows[$];
    int       drain;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rows = '{
      '{mk_req(0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 1)},
      '{mk_req(5, -7, 9, 5, -7, 9, 65535), 1'b1, mk_rsp(5, -7, 9, 1)},
      '{mk_req(0, 0, 0, 100, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0)},
      '{mk_req(-32768, -32768, -32768, 32767, 32767, 32767, 0), 1'b1,
        mk_rsp(-32768, -32768, -32768, 0)},
      '{mk_req(-32768, -32768, -32768, 32767, 32767, 32767, 65535), 1'b0, '0},
      '{mk_req(32767, 32767, 32767, -32768, -32768, -32768, 65535), 1'b0, '0},
      '{mk_req(32767, -32768, 0, -32768, 32767, 0, 1), 1'b0, '0},
      '{mk_req(0, 0, 0, 3, 4, 0, 5), 1'b1, mk_rsp(3, 4, 0, 1)},
      '{mk_req(0, 0, 0, 3, 4, 0, 4), 1'b0, '0},
      '{mk_req(0, 0, 0, 30, 40, 0, 25), 1'b0, '0},
      '{mk_req(0, 0, 0, 1, 1, 1, 1), 1'b0, '0},
      '{mk_req(-100, 200, -300, 100, -200, 300, 50), 1'b0, '0},
      '{mk_req(1000, 1000, 1000, -1000, -1000, -1000, 3464), 1'b0, '0},
      '{mk_req(0, 0, 0, 0, 0, -32768, 32768), 1'b1, mk_rsp(0, 0, -32768, 1)},
      '{mk_req(0, 0, 0, 0, 0, 32767, 32766), 1'b0, '0},
      '{mk_req(-1, -1, -1, 1, 1, 1, 65535), 1'b1, mk_rsp(1, 1, 1, 1)},
      '{mk_req(21845, -21846, 0, -21846, 21845, 0, 255), 1'b0, '0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      check_directed(rows[i]);
      send_beat(rows[i].req);
    end

    // three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 72 : 0;
      snk_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 8 : 0;
      for (int n = 0; n < RandomBeats / 3; n++) begin
        if (n % 100 < 20) begin
          src_idle_pct = 0;
        end else begin
          src_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 72 : 0;
        end
        send_beat(rand_req());
      end
    end
    req_ch.valid <= 1'b0;

    drain = 0;
    while (moves_due.size() != 0 && drain < 50 * WatchLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (LatencyCycles + 10) @(posedge clk);
    if (errors == 0 && moves_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ step_limited_move_3d.f @@
design/slm3_pkg.sv
design/slm3_if.sv
design/slm3_div.sv
design/slm3_sqrt.sv
design/step_limited_move_3d.sv
design/slm3_check.sv
bench/step_limited_move_3d_test.sv
